@@ src/cpwm_pkg.sv @@
package cpwm_pkg;

  typedef logic [1:0] mode_t;

  // Bits of the mode field
  localparam int unsigned MODE_START_BIT = 0;
  localparam int unsigned MODE_STOP_BIT  = 1;

  // Register index, taken from paddr[2]
  localparam logic REG_COUNT_DOWN = 1'b0;
  localparam logic REG_RELOAD     = 1'b1;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;

endpackage

@@ src/cpwm_front.sv @@
module cpwm_front #(
  parameter int unsigned COUNTER_BITS        = 24,
  parameter int unsigned OVERFLOW_COUNT_BITS = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cpwm_pkg::mode_t                mode,
  input  logic [COUNTER_BITS-1:0]        start_capture,
  input  logic [COUNTER_BITS-1:0]        stop_capture,
  input  logic                           count_down,
  input  logic [COUNTER_BITS-1:0]        reload_value,
  input  logic                           q_full,
  output logic                           push,
  output logic                           job_count_down,
  output logic [COUNTER_BITS-1:0]        job_reload,
  output logic                           job_ge,
  output logic [COUNTER_BITS-1:0]        job_diff,
  output logic [OVERFLOW_COUNT_BITS-1:0] job_r,
  output logic                           job_cfg_err
);
  import cpwm_pkg::*;

  logic [COUNTER_BITS-1:0]        start_value;
  logic [OVERFLOW_COUNT_BITS-1:0] overflow_count;
  logic                           monitoring;

  logic                           accept;
  logic                           is_start;
  logic                           is_stop;
  logic [COUNTER_BITS-1:0]        start_eff;
  logic [COUNTER_BITS-1:0]        early;
  logic [COUNTER_BITS-1:0]        late;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = mode[MODE_START_BIT];
  assign is_stop  = mode[MODE_STOP_BIT];
  assign push     = accept && is_stop;

  // A combined start and stop measures from the new start value
  assign start_eff = is_start ? start_capture : start_value;
  assign early     = count_down ? stop_capture : start_eff;
  assign late      = count_down ? start_eff : stop_capture;

  assign job_count_down = count_down;
  assign job_reload     = reload_value;
  assign job_ge         = (late >= early);
  assign job_diff       = job_ge ? (late - early) : (early - late);
  // A stop behind the start with no overflow seen implies one wrap
  assign job_r          = (!job_ge && overflow_count == '0) ?
                          OVERFLOW_COUNT_BITS'(1) : overflow_count;
  assign job_cfg_err    = !count_down && (reload_value != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value    <= '0;
      overflow_count <= '0;
      monitoring     <= 1'b0;
    end else if (accept) begin
      if (!is_start && !is_stop) begin
        if (monitoring && overflow_count != '1) begin
          overflow_count <= overflow_count + OVERFLOW_COUNT_BITS'(1);
        end
      end else begin
        if (is_start) begin
          start_value <= start_capture;
          monitoring  <= 1'b1;
        end
        if (is_stop) begin
          monitoring     <= 1'b0;
          overflow_count <= '0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push |=> !monitoring && overflow_count == '0)
    else $error("stop did not disarm the meter");

  assert property (@(posedge clk) disable iff (rst)
    accept && is_start && !is_stop |=> monitoring)
    else $error("start did not arm the meter");

  assert property (@(posedge clk) disable iff (rst)
    !monitoring |=> $stable(overflow_count) || overflow_count == '0)
    else $error("overflow counted while disarmed");

endmodule

@@ src/cpwm_queue.sv @@
module cpwm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import cpwm_pkg::*;

  logic [WIDTH-1:0]          entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign full      = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_BITS+1)'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !not_empty))
    else $error("queue overrun or underrun");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> not_empty)
    else $error("queue lost a pushed job");

endmodule

@@ src/cpwm_back.sv @@
module cpwm_back #(
  parameter int unsigned COUNTER_BITS        = 24,
  parameter int unsigned OVERFLOW_COUNT_BITS = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           pop,
  input  logic                           q_count_down,
  input  logic [COUNTER_BITS-1:0]        q_reload,
  input  logic                           q_ge,
  input  logic [COUNTER_BITS-1:0]        q_diff,
  input  logic [OVERFLOW_COUNT_BITS-1:0] q_r,
  input  logic                           q_cfg_err,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    pulse_ticks,
  output logic                           saturated,
  output logic                           config_error
);
  import cpwm_pkg::*;

  localparam int unsigned PW = COUNTER_BITS + OVERFLOW_COUNT_BITS;
  localparam int unsigned WW = (PW + 1 > 33) ? PW + 1 : 33;

  logic [PW-1:0]           base_in;
  logic [PW-1:0]           prod;

  logic                    s1_valid;
  logic [PW-1:0]           s1_base;
  logic                    s1_ge;
  logic [COUNTER_BITS-1:0] s1_diff;
  logic                    s1_cfg_err;

  logic                    out_advance;
  logic                    s1_free;
  logic [WW-1:0]           base_ext;
  logic [WW-1:0]           diff_ext;
  logic [WW-1:0]           width;
  logic                    over;

  assign out_advance = !out_valid || out_ready;
  assign s1_free     = !s1_valid || out_advance;
  assign pop         = q_valid && s1_free;

  // Period times overflow count: a shift when counting up
  assign prod    = q_reload * q_r;
  assign base_in = q_count_down ? prod : {q_r, {COUNTER_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_base    <= base_in;
      s1_ge      <= q_ge;
      s1_diff    <= q_diff;
      s1_cfg_err <= q_cfg_err;
    end
  end

  assign base_ext = WW'(s1_base);
  assign diff_ext = WW'(s1_diff);

  always_comb begin
    if (s1_ge) begin
      width = base_ext + diff_ext;
    end else if (diff_ext > base_ext) begin
      width = '0;
    end else begin
      width = base_ext - diff_ext;
    end
  end

  assign over = |width[WW-1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      pulse_ticks  <= over ? '1 : width[31:0];
      saturated    <= over;
      config_error <= s1_cfg_err;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> &pulse_ticks)
    else $error("saturated result not at full scale");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_advance |=> s1_valid && $stable(s1_base))
    else $error("stage one dropped a job under stall");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_advance |=> out_valid)
    else $error("stage one job did not reach the output");

endmodule

@@ src/capture_pulse_width_meter_core.sv @@
// Path: an accepted stop writes a job into the job queue; the period multiply is registered
//   in stage one, and the width add and saturate go into the output register.
// Throughput: 1 transaction per cycle; the 4-entry job queue and the two back-end
//   registers let input and output stall independently.
// Reset (synchronous, rst high): disarm the meter, clear start value, overflow count,
//   queue and output valid; count_down and reload_value return to zero.
module capture_pulse_width_meter_core #(
  parameter int unsigned COUNTER_BITS        = 24,
  parameter int unsigned OVERFLOW_COUNT_BITS = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  // APB-style configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Capture event transactions
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cpwm_pkg::mode_t         mode,
  input  logic [COUNTER_BITS-1:0] start_capture,
  input  logic [COUNTER_BITS-1:0] stop_capture,
  // Measured width transactions
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             pulse_ticks,
  output logic                    saturated,
  output logic                    config_error
);
  import cpwm_pkg::*;

  localparam int unsigned JW = 1 + COUNTER_BITS + 1 + COUNTER_BITS + OVERFLOW_COUNT_BITS + 1;

  // Configuration registers
  logic                           count_down;
  logic [COUNTER_BITS-1:0]        reload_value;
  logic                           cfg_write;

  // Front to queue
  logic                           push;
  logic                           q_full;
  logic                           job_count_down;
  logic [COUNTER_BITS-1:0]        job_reload;
  logic                           job_ge;
  logic [COUNTER_BITS-1:0]        job_diff;
  logic [OVERFLOW_COUNT_BITS-1:0] job_r;
  logic                           job_cfg_err;
  logic [JW-1:0]                  push_data;

  // Queue to back
  logic                           pop;
  logic                           q_valid;
  logic [JW-1:0]                  pop_data;
  logic                           q_count_down;
  logic [COUNTER_BITS-1:0]        q_reload;
  logic                           q_ge;
  logic [COUNTER_BITS-1:0]        q_diff;
  logic [OVERFLOW_COUNT_BITS-1:0] q_r;
  logic                           q_cfg_err;

  // The port never inserts wait states; a write lands on the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_down   <= 1'b0;
      reload_value <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_COUNT_DOWN: count_down   <= pwdata[0];
        REG_RELOAD:     reload_value <= pwdata[COUNTER_BITS-1:0];
        default:        count_down   <= count_down;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNT_DOWN: prdata = {31'd0, count_down};
      REG_RELOAD:     prdata = 32'(reload_value);
      default:        prdata = '0;
    endcase
  end

  // Front: track start value, overflow count and arming; classify each event
  // and hand a measurement job to the queue on every stop.
  cpwm_front #(
    .COUNTER_BITS        (COUNTER_BITS),
    .OVERFLOW_COUNT_BITS (OVERFLOW_COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .start_capture  (start_capture),
    .stop_capture   (stop_capture),
    .count_down     (count_down),
    .reload_value   (reload_value),
    .q_full         (q_full),
    .push           (push),
    .job_count_down (job_count_down),
    .job_reload     (job_reload),
    .job_ge         (job_ge),
    .job_diff       (job_diff),
    .job_r          (job_r),
    .job_cfg_err    (job_cfg_err)
  );

  // Pack the job; the queue only carries it.
  assign push_data = {job_count_down, job_reload, job_ge, job_diff, job_r, job_cfg_err};
  assign {q_count_down, q_reload, q_ge, q_diff, q_r, q_cfg_err} = pop_data;

  cpwm_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  // Back: multiply period by overflow count, then add or subtract the capture
  // distance, clamping at zero, and saturate to 32 bits in the output register.
  cpwm_back #(
    .COUNTER_BITS        (COUNTER_BITS),
    .OVERFLOW_COUNT_BITS (OVERFLOW_COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop          (pop),
    .q_count_down (q_count_down),
    .q_reload     (q_reload),
    .q_ge         (q_ge),
    .q_diff       (q_diff),
    .q_r          (q_r),
    .q_cfg_err    (q_cfg_err),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_ticks  (pulse_ticks),
    .saturated    (saturated),
    .config_error (config_error)
  );

endmodule
